@@ src/bnf_pkg.sv @@
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types, constants and command codes of the biquad notch filter core.
// ----------------------------------------------------------------------------
package bnf_pkg;

    // fixed field and datapath widths
    localparam int COEF_WIDTH    = 18;
    localparam int SUM_WIDTH     = COEF_WIDTH + 2;
    localparam int ACC_WIDTH     = 64;
    localparam int NUM_COEFS     = 6;
    localparam int CFG_IDX_WIDTH = 3;

    // defaults for the top level parameters
    localparam int DEF_COEF_FRAC_BITS   = 14;
    localparam int DEF_SAMPLE_FRAC_BITS = 8;
    localparam int DEF_SAMPLE_BITS      = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A0 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A1 = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A2 = 3'd5;

    localparam logic signed [COEF_WIDTH-1:0] COEF_RESET [NUM_COEFS] =
        '{18'sd16384, 18'sd0, 18'sd0, 18'sd16384, 18'sd0, 18'sd0};

    // request codes
    localparam logic REQ_FILTER  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // half of the 64-bit multiplicand fed to the multiplier
    localparam logic HALF_LO = 1'b0;
    localparam logic HALF_HI = 1'b1;

    typedef enum logic [2:0] {
        MA_B0,
        MA_B1,
        MA_B2,
        MA_A1,
        MA_A2,
        MA_NUM
    } mul_a_t;

    typedef enum logic {
        MB_X,
        MB_Y
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        AI_HOLD,
        AI_ZERO,
        AI_D1,
        AI_D2
    } acc_init_t;

    typedef struct packed {
        logic      load_x;
        logic      clear_d;
        mul_a_t    mul_a;
        mul_b_t    mul_b;
        logic      mul_hi;
        acc_op_t   acc_op;
        acc_init_t acc_init;
        logic      round_y;
        logic      y_from_x;
        logic      y_from_div;
        logic      div_start;
        logic      wr_d1;
        logic      wr_d2;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } dp_status_t;

endpackage

@@ src/bnf_divider.sv @@
// ----------------------------------------------------------------------------
// bnf_divider
// Signed truncating divider, 64-bit dividend by coefficient sum, one
// quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
module bnf_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bnf_pkg::ACC_WIDTH-1:0]       dividend,
    input  logic signed [bnf_pkg::SUM_WIDTH-1:0] divisor,
    output logic                                done,
    output logic [bnf_pkg::ACC_WIDTH-1:0]       quotient
);

    localparam int AW = bnf_pkg::ACC_WIDTH;
    localparam int SW = bnf_pkg::SUM_WIDTH;
    localparam int CW = $clog2(AW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dvs_reg, dvs_next;

    logic [SW:0]   shifted;
    logic          fits;
    logic [SW:0]   diff;

    assign shifted = {rem_reg, quo_reg[AW-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(AW - 1);
            neg_next   = dividend[AW-1] ^ divisor[SW-1];
            quo_next   = dividend[AW-1] ? (~dividend + 1'b1) : dividend;
            rem_next   = '0;
            dvs_next   = divisor[SW-1] ? (~divisor + 1'b1) : divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next   = fits ? diff[SW-1:0] : shifted[SW-1:0];
            quo_next   = {quo_reg[AW-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

@@ src/bnf_datapath.sv @@
// ----------------------------------------------------------------------------
// bnf_datapath
// Coefficient registers, shared multiplier with accumulator, delay words,
// rounding and output saturation of the biquad core.
// ----------------------------------------------------------------------------
module bnf_datapath #(
    parameter int COEF_FRAC_BITS   = bnf_pkg::DEF_COEF_FRAC_BITS,
    parameter int SAMPLE_FRAC_BITS = bnf_pkg::DEF_SAMPLE_FRAC_BITS,
    parameter int SAMPLE_BITS      = bnf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [bnf_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
    input  logic signed [bnf_pkg::COEF_WIDTH-1:0]   cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]           sample_in,
    output logic signed [SAMPLE_BITS-1:0]           sample_out,
    input  bnf_pkg::dp_cmd_t                        cmd,
    output bnf_pkg::dp_status_t                     status
);

    localparam int AW = bnf_pkg::ACC_WIDTH;
    localparam int HW = AW / 2;
    localparam int SW = bnf_pkg::SUM_WIDTH;
    localparam int CWID = bnf_pkg::COEF_WIDTH;
    localparam int NC = bnf_pkg::NUM_COEFS;
    localparam int PW = SW + HW + 1;

    localparam logic signed [AW-1:0] SAT_HI =
        $signed({{(AW-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - 1;

    // signed shift right with rounding half away from zero
    function automatic logic [AW-1:0] round_half_away(input logic [AW-1:0] v,
                                                      input int unsigned sh);
        logic signed [AW:0] half;
        logic signed [AW:0] sum;
        logic signed [AW:0] shifted;
        half    = $signed({{AW{1'b0}}, 1'b1} << (sh - 1));
        sum     = $signed({v[AW-1], v}) + (v[AW-1] ? half - 1 : half);
        shifted = sum >>> sh;
        return shifted[AW-1:0];
    endfunction

    logic signed [CWID-1:0] coef_reg [NC];
    logic signed [CWID-1:0] coef_next [NC];
    logic [AW-1:0]          d1_reg, d1_next;
    logic [AW-1:0]          d2_reg, d2_next;
    bnf_pkg::acc_op_t       pend_op_reg, pend_op_next;
    logic                   pend_hi_reg, pend_hi_next;
    logic [AW-1:0]          x_reg, x_next;
    logic [AW-1:0]          y_reg, y_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;

    logic signed [SW-1:0]   num_sum;
    logic signed [SW-1:0]   den_sum;
    logic signed [SW-1:0]   mul_a_val;
    logic [AW-1:0]          mul_b_src;
    logic [HW-1:0]          mul_b_half;
    logic [AW-1:0]          addend;
    logic [AW-1:0]          x_ext;
    logic signed [AW-1:0]   y_round;
    logic                   div_done;
    logic [AW-1:0]          div_quotient;

    assign num_sum = SW'(coef_reg[bnf_pkg::REG_B0]) + SW'(coef_reg[bnf_pkg::REG_B1])
                   + SW'(coef_reg[bnf_pkg::REG_B2]);
    assign den_sum = SW'(coef_reg[bnf_pkg::REG_A0]) + SW'(coef_reg[bnf_pkg::REG_A1])
                   + SW'(coef_reg[bnf_pkg::REG_A2]);

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            coef_next[i] = coef_reg[i];
            if (cfg_wr_en && (cfg_index == bnf_pkg::CFG_IDX_WIDTH'(i)))
            begin
                coef_next[i] = cfg_data;
            end
        end
    end

    // shared multiplier: a coefficient or sum(b) times one 32-bit half of x or y
    always_comb
    begin
        unique case (cmd.mul_a)
            bnf_pkg::MA_B0:  mul_a_val = SW'(coef_reg[bnf_pkg::REG_B0]);
            bnf_pkg::MA_B1:  mul_a_val = SW'(coef_reg[bnf_pkg::REG_B1]);
            bnf_pkg::MA_B2:  mul_a_val = SW'(coef_reg[bnf_pkg::REG_B2]);
            bnf_pkg::MA_A1:  mul_a_val = SW'(coef_reg[bnf_pkg::REG_A1]);
            bnf_pkg::MA_A2:  mul_a_val = SW'(coef_reg[bnf_pkg::REG_A2]);
            bnf_pkg::MA_NUM: mul_a_val = num_sum;
            default:         mul_a_val = '0;
        endcase
    end

    assign mul_b_src  = (cmd.mul_b == bnf_pkg::MB_Y) ? y_reg : x_reg;
    assign mul_b_half = (cmd.mul_hi == bnf_pkg::HALF_HI) ? mul_b_src[AW-1:HW]
                                                         : mul_b_src[HW-1:0];
    assign prod_next  = mul_a_val * $signed({1'b0, mul_b_half});

    // upper half product only counts modulo 2^32 once moved up
    assign addend = (pend_hi_reg == bnf_pkg::HALF_HI) ? {prod_reg[HW-1:0], {HW{1'b0}}}
                                                      : AW'(prod_reg);

    assign pend_op_next = cmd.acc_op;
    assign pend_hi_next = cmd.mul_hi;

    always_comb
    begin
        priority if (pend_op_reg == bnf_pkg::ACC_ADD)
        begin
            acc_next = acc_reg + addend;
        end
        else if (pend_op_reg == bnf_pkg::ACC_SUB)
        begin
            acc_next = acc_reg - addend;
        end
        else
        begin
            unique case (cmd.acc_init)
                bnf_pkg::AI_ZERO: acc_next = '0;
                bnf_pkg::AI_D1:   acc_next = d1_reg;
                bnf_pkg::AI_D2:   acc_next = d2_reg;
                default:          acc_next = acc_reg;
            endcase
        end
    end

    assign x_ext  = AW'(sample_in);
    assign x_next = cmd.load_x ? (x_ext << SAMPLE_FRAC_BITS) : x_reg;

    always_comb
    begin
        priority if (cmd.round_y)
        begin
            y_next = round_half_away(acc_reg, COEF_FRAC_BITS);
        end
        else if (cmd.y_from_x)
        begin
            y_next = x_reg;
        end
        else if (cmd.y_from_div)
        begin
            y_next = div_quotient;
        end
        else
        begin
            y_next = y_reg;
        end
    end

    assign d1_next = cmd.clear_d ? '0 : (cmd.wr_d1 ? acc_reg : d1_reg);
    assign d2_next = cmd.clear_d ? '0 : (cmd.wr_d2 ? acc_reg : d2_reg);

    assign y_round = $signed(round_half_away(y_reg, SAMPLE_FRAC_BITS));

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            priority if (y_round > SAT_HI)
            begin
                out_next = SAT_HI[SAMPLE_BITS-1:0];
            end
            else if (y_round < SAT_LO)
            begin
                out_next = SAT_LO[SAMPLE_BITS-1:0];
            end
            else
            begin
                out_next = y_round[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                coef_reg[i] <= bnf_pkg::COEF_RESET[i];
            end
            d1_reg      <= '0;
            d2_reg      <= '0;
            pend_op_reg <= bnf_pkg::ACC_NONE;
            pend_hi_reg <= bnf_pkg::HALF_LO;
        end
        else
        begin
            for (int i = 0; i < NC; i++)
            begin
                coef_reg[i] <= coef_next[i];
            end
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            pend_op_reg <= pend_op_next;
            pend_hi_reg <= pend_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    bnf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (den_sum),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status.den_zero = (den_sum == '0);
    assign status.div_done = div_done;
    assign sample_out      = out_reg;

endmodule

@@ src/bnf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bnf_ctrl
// Sequencer of the biquad core: handshakes, DC priming and the per-sample
// multiply-accumulate schedule.
// ----------------------------------------------------------------------------
module bnf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                req_type,
    output logic                res_valid,
    input  logic                res_stall,
    output bnf_pkg::dp_cmd_t    cmd,
    input  bnf_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_NUM_LO,
        S_P_NUM_HI,
        S_P_NUM_WAIT,
        S_P_DIV_START,
        S_P_DIV_WAIT,
        S_P_B2_LO,
        S_P_B2_HI,
        S_P_A2_LO,
        S_P_A2_HI,
        S_P_D2_WAIT,
        S_P_B1_LO,
        S_P_B1_HI,
        S_P_A1_LO,
        S_P_A1_HI,
        S_P_D1_WAIT,
        S_P_WR_D1,
        S_F_B0_LO,
        S_F_B0_HI,
        S_F_Y_WAIT,
        S_F_B1_LO,
        S_F_B1_HI,
        S_F_A1_LO,
        S_F_A1_HI,
        S_F_D1_WAIT,
        S_F_B2_LO,
        S_F_B2_HI,
        S_F_A2_LO,
        S_F_A2_HI,
        S_F_D2_WAIT,
        S_F_OUT
    } state_t;

    function automatic bnf_pkg::dp_cmd_t mul_cmd(input bnf_pkg::mul_a_t a,
                                                 input bnf_pkg::mul_b_t b,
                                                 input logic hi,
                                                 input bnf_pkg::acc_op_t op);
        bnf_pkg::dp_cmd_t c;
        c        = '0;
        c.mul_a  = a;
        c.mul_b  = b;
        c.mul_hi = hi;
        c.acc_op = op;
        return c;
    endfunction

    state_t state_reg, state_next;
    logic   primed_reg, primed_next;
    logic   res_valid_reg, res_valid_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next  = state_reg;
        primed_next = primed_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == bnf_pkg::REQ_RESTART)
                    begin
                        cmd.clear_d = 1'b1;
                        primed_next = 1'b0;
                    end
                    else
                    begin
                        cmd.load_x = 1'b1;
                        state_next = primed_reg ? S_F_B0_LO : S_P_NUM_LO;
                    end
                end
            end
            // dc priming: p = x * sum(b), y = p / sum(a), or y = x if sum(a) is zero
            S_P_NUM_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_NUM, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.acc_init = bnf_pkg::AI_ZERO;
                state_next   = S_P_NUM_HI;
            end
            S_P_NUM_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_NUM, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_P_NUM_WAIT;
            end
            S_P_NUM_WAIT:
            begin
                state_next = S_P_DIV_START;
            end
            S_P_DIV_START:
            begin
                if (status.den_zero)
                begin
                    cmd.y_from_x = 1'b1;
                    state_next   = S_P_B2_LO;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_P_DIV_WAIT;
                end
            end
            S_P_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.y_from_div = 1'b1;
                    state_next     = S_P_B2_LO;
                end
            end
            S_P_B2_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B2, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.acc_init = bnf_pkg::AI_ZERO;
                state_next   = S_P_B2_HI;
            end
            S_P_B2_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B2, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_P_A2_LO;
            end
            S_P_A2_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A2, bnf_pkg::MB_Y, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_SUB);
                state_next = S_P_A2_HI;
            end
            S_P_A2_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A2, bnf_pkg::MB_Y, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_SUB);
                state_next = S_P_D2_WAIT;
            end
            S_P_D2_WAIT:
            begin
                state_next = S_P_B1_LO;
            end
            // accumulator keeps the new d2 and builds d1 on top of it
            S_P_B1_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B1, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.wr_d2  = 1'b1;
                state_next = S_P_B1_HI;
            end
            S_P_B1_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B1, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_P_A1_LO;
            end
            S_P_A1_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A1, bnf_pkg::MB_Y, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_SUB);
                state_next = S_P_A1_HI;
            end
            S_P_A1_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A1, bnf_pkg::MB_Y, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_SUB);
                state_next = S_P_D1_WAIT;
            end
            S_P_D1_WAIT:
            begin
                state_next = S_P_WR_D1;
            end
            S_P_WR_D1:
            begin
                cmd.wr_d1   = 1'b1;
                primed_next = 1'b1;
                state_next  = S_F_B0_LO;
            end
            // regular step: acc = d1 + b0*x
            S_F_B0_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B0, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.acc_init = bnf_pkg::AI_D1;
                state_next   = S_F_B0_HI;
            end
            S_F_B0_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B0, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_F_Y_WAIT;
            end
            S_F_Y_WAIT:
            begin
                state_next = S_F_B1_LO;
            end
            S_F_B1_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B1, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.round_y  = 1'b1;
                cmd.acc_init = bnf_pkg::AI_D2;
                state_next   = S_F_B1_HI;
            end
            S_F_B1_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B1, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_F_A1_LO;
            end
            S_F_A1_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A1, bnf_pkg::MB_Y, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_SUB);
                state_next = S_F_A1_HI;
            end
            S_F_A1_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A1, bnf_pkg::MB_Y, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_SUB);
                state_next = S_F_D1_WAIT;
            end
            S_F_D1_WAIT:
            begin
                state_next = S_F_B2_LO;
            end
            S_F_B2_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B2, bnf_pkg::MB_X, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_ADD);
                cmd.wr_d1    = 1'b1;
                cmd.acc_init = bnf_pkg::AI_ZERO;
                state_next   = S_F_B2_HI;
            end
            S_F_B2_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_B2, bnf_pkg::MB_X, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_ADD);
                state_next = S_F_A2_LO;
            end
            S_F_A2_LO:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A2, bnf_pkg::MB_Y, bnf_pkg::HALF_LO,
                              bnf_pkg::ACC_SUB);
                state_next = S_F_A2_HI;
            end
            S_F_A2_HI:
            begin
                cmd = mul_cmd(bnf_pkg::MA_A2, bnf_pkg::MB_Y, bnf_pkg::HALF_HI,
                              bnf_pkg::ACC_SUB);
                state_next = S_F_D2_WAIT;
            end
            S_F_D2_WAIT:
            begin
                state_next = S_F_OUT;
            end
            // d2 rewrite is idempotent while waiting for the output register
            S_F_OUT:
            begin
                cmd.wr_d2 = 1'b1;
                if (!(res_valid_reg && res_stall))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid_next = cmd.load_out | (res_valid_reg & res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            primed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

@@ src/biquad_notch_filter_core.sv @@
// ----------------------------------------------------------------------------
// biquad_notch_filter_core
// Fixed-point transposed direct form II biquad with DC priming.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall, req_type, sample_in): a beat with
//   req_type restart clears both delay words and the primed flag and gives no
//   result; a filter beat gives one beat on the result channel
//   (res_valid / res_stall, sample_out).
//   one shared 20x33 multiplier does every product in two halves, with each
//   product registered before it is accumulated; req_stall stays high until a
//   sample's schedule is done. the first filter beat after reset or restart
//   first primes the delays, dividing by sum(a) in the 64-step bit-serial
//   divider unless sum(a) is zero. a restart beat leaves the core idle.
//   the result sits in an output register; the core accepts the next request
//   while it waits, and a stalled result holds until taken, the next sample
//   waiting in its last step if the register is still full.
//   reset returns all coefficients to their defaults (b0 = a0 = 1.0) and
//   leaves the filter unprimed. the user writes coefficients through
//   cfg_wr_en / cfg_index / cfg_data only while idle, unchecked by the core.
// ----------------------------------------------------------------------------
module biquad_notch_filter_core #(
    parameter int COEF_FRAC_BITS   = bnf_pkg::DEF_COEF_FRAC_BITS,
    parameter int SAMPLE_FRAC_BITS = bnf_pkg::DEF_SAMPLE_FRAC_BITS,
    parameter int SAMPLE_BITS      = bnf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bnf_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic signed [bnf_pkg::COEF_WIDTH-1:0] cfg_data,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic                                  req_type,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample_out
);

    bnf_pkg::dp_cmd_t    cmd;
    bnf_pkg::dp_status_t status;

    bnf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .status    (status)
    );

    bnf_datapath #(
        .COEF_FRAC_BITS   (COEF_FRAC_BITS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
